// ----- hw/rtl/frame_bit_field_reader_assert.svh -----
// Assertion macros for the frame bit-field reader checker.
`ifndef FRAME_BIT_FIELD_READER_ASSERT_SVH
`define FRAME_BIT_FIELD_READER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_bit_field_reader check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FBFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_bit_field_reader check failed");

`endif

// ----- hw/rtl/fbfr_pkg.sv -----
// Shared types and constants for the frame bit-field reader.
`timescale 1ns / 1ps

package fbfr_pkg;

    localparam int WORD_W      = 32;
    localparam int FIELD_W     = 16;
    localparam int FLEN_W      = 12;
    localparam int CNT_W       = 5;
    localparam int POS_W       = 5;
    localparam int SUM_W       = 6;

    // request codes on req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [FIELD_W-1:0] FIELD_MASK     = 16'hFFFF;
    localparam logic [SUM_W-1:0]   WORD_BITS      = 6'd32;
    localparam logic [SUM_W-1:0]   STRADDLE_BITS  = 6'd48;
    localparam logic [CNT_W-1:0]   MAX_COUNT      = 5'd16;

    // one classified request as it travels from the front to the back
    typedef struct packed {
        logic                 is_read;
        logic [WORD_W-1:0]    data;
        logic                 start;
        logic [FLEN_W-1:0]    bytes;
        logic [CNT_W-1:0]     nbits;   // clamped to 0..16
    } item_t;

endpackage

// ----- hw/rtl/fbfr_front.sv -----
// Front end: accepts request words, classifies them, and queues them for the back end.
`timescale 1ns / 1ps

module fbfr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [fbfr_pkg::WORD_W-1:0]   word_data,
    input  logic                          frame_start,
    input  logic [fbfr_pkg::FLEN_W-1:0]   frame_bytes,
    input  logic [fbfr_pkg::CNT_W-1:0]    bit_count,
    output logic                          item_valid,
    output fbfr_pkg::item_t               item,
    input  logic                          item_pop
);

    fbfr_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    fbfr_pkg::item_t in_item;
    logic            do_push;
    logic            do_pop;

    // classify the incoming word; oversize bit counts clamp to 16
    always_comb
    begin
        in_item.is_read = (req_type == fbfr_pkg::REQ_READ);
        in_item.data    = word_data;
        in_item.start   = frame_start;
        in_item.bytes   = frame_bytes;
        in_item.nbits   = (bit_count > fbfr_pkg::MAX_COUNT) ? fbfr_pkg::MAX_COUNT : bit_count;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/fbfr_back.sv -----
// Back end: frame store, read sequencer, and the result word register.
`timescale 1ns / 1ps

module fbfr_back
#(
    parameter int STORE_WORDS = 512
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  fbfr_pkg::item_t               item,
    output logic                          item_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [fbfr_pkg::FIELD_W-1:0]  field_value,
    output logic                          overrun
);

    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IDX_W  = $clog2(STORE_WORDS + 1);
    localparam int CMP_W  = (IDX_W + 2 > fbfr_pkg::FLEN_W) ? IDX_W + 2 : fbfr_pkg::FLEN_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STORE_WORDS);
    localparam logic [CMP_W-1:0] FRAME_CAP = CMP_W'(4 * STORE_WORDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_NEXT  = 2'd2;

    logic [fbfr_pkg::WORD_W-1:0] mem [STORE_WORDS];

    logic [1:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                widx_reg, widx_next;
    logic [IDX_W-1:0]                ridx_reg, ridx_next;
    logic [fbfr_pkg::POS_W-1:0]      bitpos_reg, bitpos_next;
    logic [fbfr_pkg::FLEN_W-1:0]     flen_reg, flen_next;
    logic                            err_reg, err_next;
    logic [fbfr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [fbfr_pkg::FIELD_W-1:0]    lo_reg, lo_next;
    logic [fbfr_pkg::WORD_W-1:0]     rdata_reg;
    logic                            rzero_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [fbfr_pkg::FIELD_W-1:0]    out_value_reg, out_value_next;
    logic                            out_ovr_reg, out_ovr_next;

    logic                            out_free;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_idx;
    logic                            wr_en;
    logic [IDX_W-1:0]                widx_eff;
    logic [fbfr_pkg::WORD_W-1:0]     word;
    logic [fbfr_pkg::SUM_W-1:0]      sum;
    logic [fbfr_pkg::FIELD_W-1:0]    mask;
    logic [fbfr_pkg::WORD_W-1:0]     near_shift;
    logic [fbfr_pkg::WORD_W-1:0]     far_shift;
    logic [IDX_W-1:0]                ridx_adv;
    logic                            past_end;

    assign out_free    = !out_valid_reg || pop;
    assign empty       = !out_valid_reg;
    assign field_value = out_value_reg;
    assign overrun     = out_ovr_reg;

    // field extraction datapath
    always_comb
    begin
        word       = rzero_reg ? '0 : rdata_reg;
        sum        = {1'b0, bitpos_reg} + {1'b0, cnt_reg};
        mask       = fbfr_pkg::FIELD_MASK >> (5'(fbfr_pkg::FIELD_W) - cnt_reg);
        near_shift = word >> (fbfr_pkg::WORD_BITS - sum);
        far_shift  = {lo_reg, word[31:16]} >> (fbfr_pkg::STRADDLE_BITS - sum);
        ridx_adv   = (ridx_reg < LAST_IDX) ? ridx_reg + 1'b1 : ridx_reg;
        past_end   = (CMP_W'({ridx_adv, 2'b00}) > CMP_W'(flen_reg));
        widx_eff   = item.start ? '0 : widx_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        ridx_next      = ridx_reg;
        bitpos_next    = bitpos_reg;
        flen_next      = flen_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg && !pop;
        out_value_next = out_value_reg;
        out_ovr_next   = out_ovr_reg;
        item_pop       = 1'b0;
        rd_en          = 1'b0;
        rd_idx         = ridx_reg;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!item.is_read)
                    begin
                        // load word: optional rewind, then store or drop
                        item_pop = 1'b1;
                        if (item.start)
                        begin
                            flen_next   = item.bytes;
                            ridx_next   = '0;
                            bitpos_next = '0;
                            err_next    = (CMP_W'(item.bytes) > FRAME_CAP);
                        end
                        widx_next = widx_eff;
                        if (widx_eff < LAST_IDX)
                        begin
                            wr_en     = 1'b1;
                            widx_next = widx_eff + 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (item.nbits == '0)
                    begin
                        // empty field: answer once the result register is free, no state change
                        if (out_free)
                        begin
                            item_pop       = 1'b1;
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_ovr_next   = err_reg;
                        end
                    end
                    else
                    begin
                        item_pop   = 1'b1;
                        rd_en      = 1'b1;
                        cnt_next   = item.nbits;
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                if (sum <= fbfr_pkg::WORD_BITS)
                begin
                    // field lies in the current word
                    if (out_free)
                    begin
                        bitpos_next = sum[fbfr_pkg::POS_W-1:0];
                        if (sum == fbfr_pkg::WORD_BITS)
                        begin
                            ridx_next = ridx_adv;
                            err_next  = err_reg || past_end;
                        end
                        out_valid_next = 1'b1;
                        out_value_next = near_shift[fbfr_pkg::FIELD_W-1:0] & mask;
                        out_ovr_next   = (sum == fbfr_pkg::WORD_BITS) ?
                                         (err_reg || past_end) : err_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // straddle: keep the low half, fetch the next word
                    lo_next    = word[15:0];
                    ridx_next  = ridx_adv;
                    err_next   = err_reg || past_end;
                    rd_en      = 1'b1;
                    rd_idx     = ridx_adv;
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                if (out_free)
                begin
                    bitpos_next    = sum[fbfr_pkg::POS_W-1:0];
                    out_valid_next = 1'b1;
                    out_value_next = far_shift[fbfr_pkg::FIELD_W-1:0] & mask;
                    out_ovr_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= '0;
            ridx_reg      <= '0;
            bitpos_reg    <= '0;
            flen_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            ridx_reg      <= ridx_next;
            bitpos_reg    <= bitpos_next;
            flen_reg      <= flen_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        lo_reg        <= lo_next;
        out_value_reg <= out_value_next;
        out_ovr_reg   <= out_ovr_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[widx_eff[ADDR_W-1:0]] <= item.data;
        end
        if (rd_en)
        begin
            rzero_reg <= (rd_idx >= LAST_IDX);
            if (rd_idx < LAST_IDX)
            begin
                rdata_reg <= mem[rd_idx[ADDR_W-1:0]];
            end
        end
    end

endmodule

// ----- hw/rtl/frame_bit_field_reader.sv -----
// Top level of the frame bit-field reader: request queue front end and execution back end.
//
// Usage:
//   Request channel (push/full): a word is taken on a clock edge with push high and
//   full low. req_type selects a load (store word_data into the frame store;
//   frame_start rewinds all positions and takes frame_bytes) or a read of
//   bit_count bits (1..16, larger counts act as 16), MSB first.
//   Result channel (empty/pop): one result word per read, none per load. The oldest
//   result sits on field_value/overrun while empty is low and leaves on pop.
//   overrun is sticky until the next frame start.
// Sequencing:
//   A two-entry request queue feeds the sequencer. Loads are stored from the idle
//   state without waiting on the result side. A read passes through the fetch state,
//   and also the next-word state when the field straddles two stored words, since
//   the frame store has one read port with a registered output; a zero-bit read
//   is answered from the idle state.
// Reset: clears the queues, positions, frame length and overrun flag; the frame
//   store contents are undefined until written.
// Stall: while a result waits, loads drain until a read enters the sequencer; up to three
//   more reads are taken: one held finished in the sequencer and two in the request queue.
`timescale 1ns / 1ps

module frame_bit_field_reader
#(
    parameter int STORE_WORDS = 512
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [fbfr_pkg::WORD_W-1:0]   word_data,
    input  logic                          frame_start,
    input  logic [fbfr_pkg::FLEN_W-1:0]   frame_bytes,
    input  logic [fbfr_pkg::CNT_W-1:0]    bit_count,
    output logic                          empty,
    input  logic                          pop,
    output logic [fbfr_pkg::FIELD_W-1:0]  field_value,
    output logic                          overrun
);

    logic            item_valid;
    logic            item_pop;
    fbfr_pkg::item_t item;

    // request queue and classification
    fbfr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .word_data   (word_data),
        .frame_start (frame_start),
        .frame_bytes (frame_bytes),
        .bit_count   (bit_count),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop)
    );

    // frame store and read sequencer
    fbfr_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .empty       (empty),
        .pop         (pop),
        .field_value (field_value),
        .overrun     (overrun)
    );

endmodule

// ----- hw/rtl/fbfr_checker.sv -----
// Port-level checker for the frame bit-field reader, bound to the top level.
`timescale 1ns / 1ps
`include "frame_bit_field_reader_assert.svh"

module fbfr_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [fbfr_pkg::FIELD_W-1:0]  field_value,
    input  logic                          overrun
);

    // leaving reset, no result is pending and requests are taken
    `FBFR_ASSERT_NOW(a_reset_clean, $rose(rst_n), empty && !full)

    // the request queue only fills up after a word was pushed
    `FBFR_ASSERT_NOW(a_full_after_push, $rose(full), $past(push))

    // a waiting result word holds until popped
    `FBFR_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(field_value) && $stable(overrun))

endmodule

bind frame_bit_field_reader fbfr_checker u_fbfr_checker (.*);

// ----- sim/tb_frame_bit_field_reader.sv -----
// Self-checking testbench for frame_bit_field_reader: directed and random traffic with a predictor.
`timescale 1ns / 1ps

module tb_frame_bit_field_reader;

    localparam int STORE_DEPTH  = 512;
    localparam int RANDOM_ITEMS = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int END_CYCLES   = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [fbfr_pkg::FIELD_W-1:0] value;
        logic                         flag;
    } field_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic                          req_type = fbfr_pkg::REQ_LOAD;
    logic [fbfr_pkg::WORD_W-1:0]   word_data = '0;
    logic                          frame_start = 1'b0;
    logic [fbfr_pkg::FLEN_W-1:0]   frame_bytes = '0;
    logic [fbfr_pkg::CNT_W-1:0]    bit_count = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [fbfr_pkg::FIELD_W-1:0]  field_value;
    logic                          overrun;

    // predicted block state
    logic [fbfr_pkg::WORD_W-1:0]   frame_mem [STORE_DEPTH];
    bit                            mem_written [STORE_DEPTH];
    logic [9:0]                    wr_ptr = '0;
    logic [9:0]                    rd_ptr = '0;
    logic [fbfr_pkg::POS_W-1:0]    bit_ofs = '0;
    logic [fbfr_pkg::FLEN_W-1:0]   frame_len = '0;
    logic                          sticky_err = 1'b0;

    field_result_t       expected_fields[$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  send_steady_left = 0;
    bit                  burst_send = 1'b0;
    bit                  hold_pending = 1'b0;

    frame_bit_field_reader #(.STORE_WORDS(STORE_DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .word_data   (word_data),
        .frame_start (frame_start),
        .frame_bytes (frame_bytes),
        .bit_count   (bit_count),
        .empty       (empty),
        .pop         (pop),
        .field_value (field_value),
        .overrun     (overrun)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [fbfr_pkg::WORD_W-1:0] stored_word(input logic [9:0] idx);
        if (idx >= STORE_DEPTH)
            return '0;
        return frame_mem[idx];
    endfunction

    function automatic bit word_ready(input logic [9:0] idx);
        return (idx >= STORE_DEPTH) || mem_written[idx];
    endfunction

    // a read must never touch a store entry that was never written
    function automatic bit read_is_legal(input logic [fbfr_pkg::CNT_W-1:0] cnt);
        logic [fbfr_pkg::CNT_W-1:0] n;
        logic [fbfr_pkg::SUM_W-1:0] sum;
        logic [9:0]                 nxt;
        n = (cnt > fbfr_pkg::MAX_COUNT) ? fbfr_pkg::MAX_COUNT : cnt;
        if (n == 0)
            return 1'b1;
        if (!word_ready(rd_ptr))
            return 1'b0;
        sum = {1'b0, bit_ofs} + n;
        nxt = (rd_ptr < STORE_DEPTH) ? rd_ptr + 10'd1 : rd_ptr;
        if (sum > fbfr_pkg::WORD_BITS)
            return word_ready(nxt);
        return 1'b1;
    endfunction

    // move to the next stored word; flag once its byte address passes the frame end
    task automatic step_word();
        if (rd_ptr < STORE_DEPTH)
            rd_ptr++;
        if ({rd_ptr, 2'b00} > frame_len)
            sticky_err = 1'b1;
    endtask

    task automatic apply_load(input logic start, input logic [fbfr_pkg::FLEN_W-1:0] bytes,
                              input logic [fbfr_pkg::WORD_W-1:0] data);
        if (start)
        begin
            frame_len  = bytes;
            wr_ptr     = '0;
            rd_ptr     = '0;
            bit_ofs    = '0;
            sticky_err = (bytes > 4 * STORE_DEPTH);
        end
        if (wr_ptr < STORE_DEPTH)
        begin
            frame_mem[wr_ptr]   = data;
            mem_written[wr_ptr] = 1'b1;
            wr_ptr++;
        end
        else
            sticky_err = 1'b1;
    endtask

    task automatic apply_read(input logic [fbfr_pkg::CNT_W-1:0] cnt);
        logic [fbfr_pkg::CNT_W-1:0]   n;
        logic [fbfr_pkg::SUM_W-1:0]   sum;
        logic [fbfr_pkg::FIELD_W-1:0] mask;
        logic [fbfr_pkg::FIELD_W-1:0] value;
        logic [fbfr_pkg::WORD_W-1:0]  cur;
        logic [fbfr_pkg::WORD_W-1:0]  nxt;
        field_result_t                res;
        n = (cnt > fbfr_pkg::MAX_COUNT) ? fbfr_pkg::MAX_COUNT : cnt;
        value = '0;
        if (n != 0)
        begin
            mask = fbfr_pkg::FIELD_MASK >> (fbfr_pkg::MAX_COUNT - n);
            sum  = {1'b0, bit_ofs} + n;
            cur  = stored_word(rd_ptr);
            if (sum <= fbfr_pkg::WORD_BITS)
            begin
                value = 16'((cur >> (fbfr_pkg::WORD_BITS - sum)) & mask);
                if (sum == fbfr_pkg::WORD_BITS)
                begin
                    bit_ofs = '0;
                    step_word();
                end
                else
                    bit_ofs = sum[fbfr_pkg::POS_W-1:0];
            end
            else
            begin
                // straddle: low half of this word, high half of the next
                step_word();
                nxt = stored_word(rd_ptr);
                value = 16'(({cur[15:0], nxt[31:16]} >> (fbfr_pkg::STRADDLE_BITS - sum))
                            & mask);
                bit_ofs = 5'(sum - fbfr_pkg::WORD_BITS);
            end
        end
        res.value = value;
        res.flag  = sticky_err;
        expected_fields.push_back(res);
    endtask

    // ---------------- stimulus helpers ----------------

    // mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic int next_send_gap();
        if (burst_send)
            return 0;
        if (send_steady_left > 0)
        begin
            send_steady_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 2)
            send_steady_left = $urandom_range(20, 80);
        return pick_idle();
    endfunction

    // offer one word and hold it until taken, then predict it
    task automatic send_word(input logic rt, input logic [fbfr_pkg::WORD_W-1:0] d,
                             input logic fs, input logic [fbfr_pkg::FLEN_W-1:0] fb,
                             input logic [fbfr_pkg::CNT_W-1:0] bc);
        int gap;
        gap = next_send_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        req_type    <= rt;
        word_data   <= d;
        frame_start <= fs;
        frame_bytes <= fb;
        bit_count   <= bc;
        do
            @(posedge clk);
        while (full !== 1'b0);
        if (rt == fbfr_pkg::REQ_LOAD)
            apply_load(fs, fb, d);
        else
            apply_read(bc);
        items_sent++;
    endtask

    task automatic load_word(input logic start, input logic [fbfr_pkg::FLEN_W-1:0] bytes,
                             input logic [fbfr_pkg::WORD_W-1:0] data);
        send_word(fbfr_pkg::REQ_LOAD, data, start, start ? bytes : 12'($urandom),
                  5'($urandom));
    endtask

    // read with junk in the unused fields; shrink a straddle that would hit an
    // unwritten word, and load a word instead if even that is not possible
    task automatic read_bits(input logic [fbfr_pkg::CNT_W-1:0] cnt);
        logic [fbfr_pkg::CNT_W-1:0] n;
        n = cnt;
        if (!read_is_legal(n) && word_ready(rd_ptr))
            n = 5'(fbfr_pkg::WORD_BITS - bit_ofs);
        if (read_is_legal(n))
            send_word(fbfr_pkg::REQ_READ, $urandom, 1'($urandom), 12'($urandom), n);
        else
            send_word(fbfr_pkg::REQ_LOAD, $urandom, 1'b0, 12'($urandom), 5'($urandom));
    endtask

    function automatic logic [fbfr_pkg::CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 10)
            return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    task automatic wait_results_drained();
        push <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- tests ----------------

    // field extremes, zero and oversized counts, straddles, frame end, oversize frames
    task automatic test_directed();
        load_word(1'b1, 12'd12, 32'h8000_0001);
        load_word(1'b0, '0, 32'hFFFF_FFFF);
        load_word(1'b0, '0, 32'h0000_0000);
        read_bits(5'd1);
        read_bits(5'd0);
        read_bits(5'd16);
        read_bits(5'd31);
        read_bits(5'd17);
        read_bits(5'd16);
        read_bits(5'd15);
        read_bits(5'd16);
        load_word(1'b0, '0, 32'hA5A5_5A5A);
        read_bits(5'd16);
        read_bits(5'd16);
        // empty frame: first word step already runs past the end
        load_word(1'b1, 12'd0, 32'h1234_5678);
        read_bits(5'd8);
        read_bits(5'd31);
        read_bits(5'd16);
        // oversize frame lengths, largest legal length in between
        load_word(1'b1, 12'd4095, 32'hDEAD_BEEF);
        read_bits(5'd16);
        load_word(1'b1, 12'd2048, 32'h0000_0000);
        read_bits(5'd12);
        load_word(1'b1, 12'd2049, 32'hFFFF_FFFF);
        read_bits(5'd1);
    endtask

    // whole frames with random content, some short, some cut off, some oversize
    task automatic test_random_frames();
        int stop_at;
        int nwords;
        int loads_left;
        int bits_left;
        int kind;
        int bytes;
        logic [fbfr_pkg::CNT_W-1:0] cnt;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                bytes = nwords * 4 - $urandom_range(0, 3);
            else if (kind == 7)
                bytes = $urandom_range(0, 4095);
            else if (kind == 8)
                bytes = $urandom_range(2049, 4095);
            else
                bytes = $urandom_range(0, nwords * 4);
            load_word(1'b1, 12'(bytes), $urandom);
            loads_left = nwords - 1;
            bits_left  = nwords * 32 + $urandom_range(0, 80);
            while (loads_left > 0 || bits_left > 0)
            begin
                if (loads_left > 0 && (bits_left <= 0 || $urandom_range(0, 1) == 1))
                begin
                    load_word(1'b0, '0, $urandom);
                    loads_left--;
                end
                else
                begin
                    cnt = pick_count();
                    read_bits(cnt);
                    bits_left -= (cnt == 0) ? 1 :
                                 ((cnt > fbfr_pkg::MAX_COUNT) ? 16 : int'(cnt));
                end
            end
        end
    endtask

    // receiver holds off while reads keep coming, so the block fills and stalls
    task automatic test_backpressure();
        load_word(1'b1, 12'd32, $urandom);
        repeat (7) load_word(1'b0, '0, $urandom);
        burst_send   = 1'b1;
        hold_pending = 1'b1;
        repeat (24) read_bits(5'($urandom_range(1, 10)));
        burst_send = 1'b0;
        wait_results_drained();
    endtask

    // fill the store, read through it into saturation, then overflow the store
    task automatic test_full_store();
        load_word(1'b1, 12'd2048, $urandom);
        repeat (STORE_DEPTH - 1) load_word(1'b0, '0, $urandom);
        while (rd_ptr < STORE_DEPTH)
            read_bits(5'($urandom_range(16, 31)));
        repeat (6) read_bits(5'($urandom_range(1, 31)));
        repeat (2) load_word(1'b0, '0, $urandom);
        repeat (3) read_bits(pick_count());
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_results_drained();
        test_random_frames();
        wait_results_drained();
        test_backpressure();
        test_full_store();
        wait_results_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ---------------- result side ----------------

    task automatic check_field(input logic [fbfr_pkg::FIELD_W-1:0] got_value,
                               input logic got_flag);
        field_result_t want;
        if (expected_fields.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result word: value=%h overrun=%b", got_value, got_flag);
            return;
        end
        want = expected_fields.pop_front();
        if (got_value !== want.value)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("field_value mismatch: expected %h, got %h", want.value, got_value);
        end
        if (got_flag !== want.flag)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("overrun mismatch: expected %b, got %b", want.flag, got_flag);
        end
    endtask

    // pop with random stalls, steady stretches, and one long hold on request
    initial
    begin
        int stall_left;
        int hold_left;
        int steady_left;
        stall_left  = 0;
        hold_left   = 0;
        steady_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_field(field_value, overrun);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (steady_left > 0)
                    steady_left--;
                else
                begin
                    stall_left = pick_idle();
                    if ($urandom_range(0, 49) == 0)
                        steady_left = $urandom_range(30, 120);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

// ----- frame_bit_field_reader.f -----
+incdir+hw/rtl
hw/rtl/fbfr_pkg.sv
hw/rtl/fbfr_front.sv
hw/rtl/fbfr_back.sv
hw/rtl/frame_bit_field_reader.sv
hw/rtl/fbfr_checker.sv
sim/tb_frame_bit_field_reader.sv
